// ===== rtl/gfe_pkg.sv =====
package gfe_pkg;

    // Problem sizing
    localparam int GENE_BITS = 10;
    localparam int POP_MAX   = 512;
    localparam int CHROM_W   = 2 * GENE_BITS;
    localparam int SLOT_W    = $clog2(POP_MAX);

    // Result widths: value Q12.16, fitness Q13.16
    localparam int VAL_W = 28;
    localparam int FIT_W = 29;

    // Datapath widths
    localparam int XM_W    = 18;  // |x| in Q16, up to 2.048
    localparam int XSQ_W   = 19;  // x1^2 in Q16
    localparam int D_W     = 19;  // |x1^2 - x2|
    localparam int E_W     = 18;  // |1 - x1|
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = 45;

    localparam int ONE_Q16    = 65536;
    localparam int HALF_Q16   = 32768;
    localparam int FRAC_SHIFT = 16;
    localparam int ROSEN_K    = 100;

    // Gene to coordinate: x = 2^24 * |2g - M| / (125 * M), split into an integer
    // part times k plus a rounded fractional product k * RECIP >> RECIP_SHIFT.
    localparam longint GENE_MAX    = (longint'(1) << GENE_BITS) - 1;
    localparam longint X_DEN       = 125 * GENE_MAX;
    localparam longint X_INT       = (longint'(1) << 24) / X_DEN;
    localparam longint X_FRAC      = (longint'(1) << 24) - X_INT * X_DEN;
    localparam int     RECIP_SHIFT = 28;
    localparam longint X_RECIP     = ((X_FRAC << RECIP_SHIFT) + X_DEN - 1) / X_DEN;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int OFFSET_W   = 10;
    localparam int CEIL_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_OPT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_CEILING = 2'd2;

    localparam logic [CEIL_W-1:0] CEIL_RESET = 12'd100;

    // Evaluation sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X1,
        ST_X2,
        ST_SQ,
        ST_DIFF,
        ST_D,
        ST_D100,
        ST_DD,
        ST_EE,
        ST_VAL,
        ST_FIT,
        ST_UPD
    } eval_state_t;

    typedef struct packed {
        logic fit_load;
        logic upd;
    } gfe_ctl_t;

    typedef struct packed {
        logic [VAL_W-1:0]   obj_value;
        logic [FIT_W-1:0]   fitness;
        logic [SLOT_W-1:0]  best_slot;
        logic [SLOT_W-1:0]  worst_slot;
        logic [FIT_W-1:0]   elite_fitness;
        logic [CHROM_W-1:0] elite_genes;
        logic               generation_done;
    } gfe_result_t;

endpackage

// ===== rtl/ga_fitness_eval_tracker_unit.sv =====
// Rosenbrock fitness evaluator with generation best/worst and elite tracking.
//
// Input channel (s_*): one chromosome per item, with last_item marking the
// final individual of a generation and new_run marking generation zero.
// Result channel (m_*): one result per item: objective value, fitness, best
// and worst slot so far, elite fitness and genes, and generation_done.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write opt_mode (0), fit_offset
// (1) and fit_ceiling (2); write only while no item is in flight.
//
// Sequencing: an accepted item runs through an 11-step sequencer around one shared
// 26x19 multiplier (two gene decodes, x1^2, 100*d, d*(100d), e^2). The result
// is registered as the sequencer leaves its last step, and s_ready returns in
// the same cycle; the block takes no new item until the current one is through.
// A result waiting in the output register does not block the next item; the
// sequencer only holds in its last step if the previous result is still there.
// Reset: synchronous, clears all tracking state, the elite and the registers
// (fit_ceiling returns to 100); m_valid drops and s_ready rises.
module ga_fitness_eval_tracker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gfe_pkg::CHROM_W-1:0]       s_chromosome,
    input  logic                              s_last_item,
    input  logic                              s_new_run,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gfe_pkg::VAL_W-1:0]         m_obj_value,
    output logic [gfe_pkg::FIT_W-1:0]         m_fitness,
    output logic [gfe_pkg::SLOT_W-1:0]        m_best_slot,
    output logic [gfe_pkg::SLOT_W-1:0]        m_worst_slot,
    output logic [gfe_pkg::FIT_W-1:0]         m_elite_fitness,
    output logic [gfe_pkg::CHROM_W-1:0]       m_elite_genes,
    output logic                              m_generation_done,
    input  logic                              cfg_wr_en,
    input  logic [gfe_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gfe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    gfe_pkg::gfe_ctl_t           ctl;
    gfe_pkg::gfe_result_t        result;
    gfe_pkg::gfe_result_t        res_reg;
    logic                        m_valid_reg;
    logic                        out_free;
    logic [gfe_pkg::VAL_W-1:0]   val;
    logic [gfe_pkg::CHROM_W-1:0] chrom;
    logic                        last;
    logic                        new_run;

    assign out_free = !m_valid_reg || m_ready;

    gfe_eval u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_chrom   (s_chromosome),
        .in_last    (s_last_item),
        .in_new_run (s_new_run),
        .out_free   (out_free),
        .ctl        (ctl),
        .val        (val),
        .chrom      (chrom),
        .last       (last),
        .new_run    (new_run)
    );

    gfe_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .val       (val),
        .chrom     (chrom),
        .last      (last),
        .new_run   (new_run),
        .result    (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.upd) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.upd) begin
            res_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_obj_value       = res_reg.obj_value;
    assign m_fitness         = res_reg.fitness;
    assign m_best_slot       = res_reg.best_slot;
    assign m_worst_slot      = res_reg.worst_slot;
    assign m_elite_fitness   = res_reg.elite_fitness;
    assign m_elite_genes     = res_reg.elite_genes;
    assign m_generation_done = res_reg.generation_done;

endmodule

// ===== rtl/gfe_eval.sv =====
module gfe_eval (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [gfe_pkg::CHROM_W-1:0]    in_chrom,
    input  logic                           in_last,
    input  logic                           in_new_run,
    input  logic                           out_free,
    output gfe_pkg::gfe_ctl_t              ctl,
    output logic [gfe_pkg::VAL_W-1:0]      val,
    output logic [gfe_pkg::CHROM_W-1:0]    chrom,
    output logic                           last,
    output logic                           new_run
);

    gfe_pkg::eval_state_t state_reg, state_next;

    logic [gfe_pkg::CHROM_W-1:0] chrom_reg;
    logic                        last_reg;
    logic                        new_run_reg;
    logic [gfe_pkg::PROD_W-1:0]  prod_reg;
    logic [gfe_pkg::XM_W-1:0]    x1m_reg;
    logic [gfe_pkg::XM_W-1:0]    x2m_reg;
    logic [gfe_pkg::XSQ_W-1:0]   x1sq_reg;
    logic [gfe_pkg::D_W-1:0]     d_reg;
    logic [gfe_pkg::E_W-1:0]     e_reg;
    logic [gfe_pkg::VAL_W-1:0]   val_reg;

    logic [gfe_pkg::GENE_BITS-1:0] g1, g2, k1, k2, k_sel;
    logic [gfe_pkg::GENE_BITS:0]   k1_wide, k2_wide;
    logic                          neg1, neg2;
    logic [gfe_pkg::PROD_W-1:0]    x_rnd;
    logic [gfe_pkg::XM_W-1:0]      xm_calc;
    logic [gfe_pkg::MUL_A_W-1:0]   mul_a;
    logic [gfe_pkg::MUL_B_W-1:0]   mul_b;
    logic [gfe_pkg::PROD_W-1:0]    mul_p;
    logic [gfe_pkg::PROD_W-1:0]    sq_rnd;
    logic [gfe_pkg::E_W-1:0]       e_calc;
    logic [gfe_pkg::D_W-1:0]       d_calc;
    logic [gfe_pkg::PROD_W-1:0]    v_rnd;
    logic [gfe_pkg::VAL_W-1:0]     v_sat;

    // Gene magnitudes |2g - M|; sign is negative when the gene's top bit is clear
    assign g1      = chrom_reg[gfe_pkg::GENE_BITS-1:0];
    assign g2      = chrom_reg[gfe_pkg::CHROM_W-1:gfe_pkg::GENE_BITS];
    assign neg1    = ~g1[gfe_pkg::GENE_BITS-1];
    assign neg2    = ~g2[gfe_pkg::GENE_BITS-1];
    assign k1_wide = neg1 ? ((gfe_pkg::GENE_BITS+1)'(gfe_pkg::GENE_MAX) - {g1, 1'b0})
                          : ({g1, 1'b0} - (gfe_pkg::GENE_BITS+1)'(gfe_pkg::GENE_MAX));
    assign k2_wide = neg2 ? ((gfe_pkg::GENE_BITS+1)'(gfe_pkg::GENE_MAX) - {g2, 1'b0})
                          : ({g2, 1'b0} - (gfe_pkg::GENE_BITS+1)'(gfe_pkg::GENE_MAX));
    assign k1      = k1_wide[gfe_pkg::GENE_BITS-1:0];
    assign k2      = k2_wide[gfe_pkg::GENE_BITS-1:0];

    // |x| = k * X_INT + round(k * RECIP / 2^RECIP_SHIFT), product taken from prod_reg
    assign k_sel   = (state_reg == gfe_pkg::ST_X2) ? k1 : k2;
    assign x_rnd   = (prod_reg + gfe_pkg::PROD_W'(longint'(1) << (gfe_pkg::RECIP_SHIFT - 1)))
                     >> gfe_pkg::RECIP_SHIFT;
    assign xm_calc = gfe_pkg::XM_W'(k_sel) * gfe_pkg::XM_W'(gfe_pkg::X_INT)
                     + x_rnd[gfe_pkg::XM_W-1:0];

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            gfe_pkg::ST_X1: begin
                mul_a = gfe_pkg::MUL_A_W'(gfe_pkg::X_RECIP);
                mul_b = gfe_pkg::MUL_B_W'(k1);
            end
            gfe_pkg::ST_X2: begin
                mul_a = gfe_pkg::MUL_A_W'(gfe_pkg::X_RECIP);
                mul_b = gfe_pkg::MUL_B_W'(k2);
            end
            gfe_pkg::ST_SQ: begin
                mul_a = gfe_pkg::MUL_A_W'(x1m_reg);
                mul_b = gfe_pkg::MUL_B_W'(x1m_reg);
            end
            gfe_pkg::ST_D100: begin
                mul_a = gfe_pkg::MUL_A_W'(gfe_pkg::ROSEN_K);
                mul_b = d_reg;
            end
            gfe_pkg::ST_DD: begin
                mul_a = prod_reg[gfe_pkg::MUL_A_W-1:0];
                mul_b = d_reg;
            end
            gfe_pkg::ST_EE: begin
                mul_a = gfe_pkg::MUL_A_W'(e_reg);
                mul_b = gfe_pkg::MUL_B_W'(e_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = gfe_pkg::PROD_W'(mul_a) * gfe_pkg::PROD_W'(mul_b);

    // x1^2 back to Q16, and |1 - x1|
    assign sq_rnd = (prod_reg + gfe_pkg::PROD_W'(gfe_pkg::HALF_Q16)) >> gfe_pkg::FRAC_SHIFT;
    always_comb begin
        if (neg1) begin
            e_calc = gfe_pkg::E_W'(gfe_pkg::ONE_Q16) + x1m_reg;
        end else if (x1m_reg >= gfe_pkg::XM_W'(gfe_pkg::ONE_Q16)) begin
            e_calc = x1m_reg - gfe_pkg::E_W'(gfe_pkg::ONE_Q16);
        end else begin
            e_calc = gfe_pkg::E_W'(gfe_pkg::ONE_Q16) - x1m_reg;
        end
    end

    // |x1^2 - x2|
    always_comb begin
        if (neg2) begin
            d_calc = x1sq_reg + gfe_pkg::D_W'(x2m_reg);
        end else if (x1sq_reg >= gfe_pkg::XSQ_W'(x2m_reg)) begin
            d_calc = x1sq_reg - gfe_pkg::D_W'(x2m_reg);
        end else begin
            d_calc = gfe_pkg::D_W'(x2m_reg) - x1sq_reg;
        end
    end

    // Final rounding to Q16 with saturation
    assign v_rnd = (prod_reg + gfe_pkg::PROD_W'(gfe_pkg::HALF_Q16)) >> gfe_pkg::FRAC_SHIFT;
    assign v_sat = (|v_rnd[gfe_pkg::PROD_W-1:gfe_pkg::VAL_W]) ? '1
                                                              : v_rnd[gfe_pkg::VAL_W-1:0];

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gfe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctl.fit_load = 1'b0;
        ctl.upd      = 1'b0;
        unique case (state_reg)
            gfe_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = gfe_pkg::ST_X1;
                end
            end
            gfe_pkg::ST_X1:   state_next = gfe_pkg::ST_X2;
            gfe_pkg::ST_X2:   state_next = gfe_pkg::ST_SQ;
            gfe_pkg::ST_SQ:   state_next = gfe_pkg::ST_DIFF;
            gfe_pkg::ST_DIFF: state_next = gfe_pkg::ST_D;
            gfe_pkg::ST_D:    state_next = gfe_pkg::ST_D100;
            gfe_pkg::ST_D100: state_next = gfe_pkg::ST_DD;
            gfe_pkg::ST_DD:   state_next = gfe_pkg::ST_EE;
            gfe_pkg::ST_EE:   state_next = gfe_pkg::ST_VAL;
            gfe_pkg::ST_VAL:  state_next = gfe_pkg::ST_FIT;
            gfe_pkg::ST_FIT: begin
                ctl.fit_load = 1'b1;
                state_next   = gfe_pkg::ST_UPD;
            end
            gfe_pkg::ST_UPD: begin
                // hold until the output register can take the result
                if (out_free) begin
                    ctl.upd    = 1'b1;
                    state_next = gfe_pkg::ST_IDLE;
                end
            end
            default: state_next = gfe_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gfe_pkg::ST_IDLE: begin
                if (in_valid) begin
                    chrom_reg   <= in_chrom;
                    last_reg    <= in_last;
                    new_run_reg <= in_new_run;
                end
            end
            gfe_pkg::ST_X1: begin
                prod_reg <= mul_p;
            end
            gfe_pkg::ST_X2: begin
                x1m_reg  <= xm_calc;
                prod_reg <= mul_p;
            end
            gfe_pkg::ST_SQ: begin
                x2m_reg  <= xm_calc;
                prod_reg <= mul_p;
            end
            gfe_pkg::ST_DIFF: begin
                x1sq_reg <= sq_rnd[gfe_pkg::XSQ_W-1:0];
                e_reg    <= e_calc;
            end
            gfe_pkg::ST_D: begin
                d_reg <= d_calc;
            end
            gfe_pkg::ST_D100, gfe_pkg::ST_DD: begin
                prod_reg <= mul_p;
            end
            gfe_pkg::ST_EE: begin
                prod_reg <= prod_reg + mul_p;
            end
            gfe_pkg::ST_VAL: begin
                val_reg <= v_sat;
            end
            default: begin
            end
        endcase
    end

    assign val     = val_reg;
    assign chrom   = chrom_reg;
    assign last    = last_reg;
    assign new_run = new_run_reg;

endmodule

// ===== rtl/gfe_track.sv =====
module gfe_track (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gfe_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  gfe_pkg::gfe_ctl_t                 ctl,
    input  logic [gfe_pkg::VAL_W-1:0]         val,
    input  logic [gfe_pkg::CHROM_W-1:0]       chrom,
    input  logic                              last,
    input  logic                              new_run,
    output gfe_pkg::gfe_result_t              result
);

    logic                          opt_mode_reg;
    logic [gfe_pkg::OFFSET_W-1:0]  fit_offset_reg;
    logic [gfe_pkg::CEIL_W-1:0]    fit_ceiling_reg;

    logic [gfe_pkg::FIT_W-1:0]     fit_reg;
    logic [gfe_pkg::SLOT_W-1:0]    item_count_reg, item_count_next;
    logic [gfe_pkg::FIT_W-1:0]     best_fit_reg, best_fit_next;
    logic [gfe_pkg::SLOT_W-1:0]    best_pos_reg, best_pos_next;
    logic [gfe_pkg::CHROM_W-1:0]   best_genes_reg, best_genes_next;
    logic [gfe_pkg::FIT_W-1:0]     worst_fit_reg, worst_fit_next;
    logic [gfe_pkg::SLOT_W-1:0]    worst_pos_reg, worst_pos_next;
    logic [gfe_pkg::FIT_W-1:0]     elite_fit_reg, elite_fit_next;
    logic [gfe_pkg::CHROM_W-1:0]   elite_chrom_reg, elite_chrom_next;

    logic [gfe_pkg::FIT_W:0]       max_sum;
    logic [gfe_pkg::VAL_W-1:0]     ceil_q16;
    logic [gfe_pkg::FIT_W-1:0]     fit_calc;
    logic                          first, take_best, take_worst, new_best, elite_ge;

    // Configuration writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opt_mode_reg    <= 1'b0;
            fit_offset_reg  <= '0;
            fit_ceiling_reg <= gfe_pkg::CEIL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gfe_pkg::CFG_OPT_MODE:    opt_mode_reg    <= cfg_wdata[0];
                gfe_pkg::CFG_FIT_OFFSET:  fit_offset_reg  <= cfg_wdata[gfe_pkg::OFFSET_W-1:0];
                gfe_pkg::CFG_FIT_CEILING: fit_ceiling_reg <= cfg_wdata[gfe_pkg::CEIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Fitness: value + offset, or ceiling - value floored at zero
    assign max_sum  = (gfe_pkg::FIT_W+1)'(val)
                      + (gfe_pkg::FIT_W+1)'({fit_offset_reg, 16'd0});
    assign ceil_q16 = gfe_pkg::VAL_W'({fit_ceiling_reg, 16'd0});
    always_comb begin
        if (opt_mode_reg) begin
            fit_calc = (val < ceil_q16) ? gfe_pkg::FIT_W'(ceil_q16 - val) : '0;
        end else begin
            fit_calc = max_sum[gfe_pkg::FIT_W] ? '1 : max_sum[gfe_pkg::FIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fit_load) begin
            fit_reg <= fit_calc;
        end
    end

    // Best/worst within the generation, elite across generations
    assign first      = (item_count_reg == '0);
    assign take_best  = !first && (fit_reg > best_fit_reg);
    assign take_worst = !first && !take_best && (fit_reg < worst_fit_reg);
    assign new_best   = first || take_best;
    assign elite_ge   = new_best ? (fit_reg >= elite_fit_reg) : (best_fit_reg >= elite_fit_reg);

    always_comb begin
        best_fit_next    = new_best ? fit_reg : best_fit_reg;
        best_genes_next  = new_best ? chrom : best_genes_reg;
        best_pos_next    = new_best ? item_count_reg : best_pos_reg;
        worst_fit_next   = (first || take_worst) ? fit_reg : worst_fit_reg;
        worst_pos_next   = (first || take_worst) ? item_count_reg : worst_pos_reg;
        elite_fit_next   = elite_fit_reg;
        elite_chrom_next = elite_chrom_reg;
        if (last && (new_run || elite_ge)) begin
            elite_fit_next   = best_fit_next;
            elite_chrom_next = best_genes_next;
        end
        if (last) begin
            item_count_next = '0;
        end else if (item_count_reg < gfe_pkg::SLOT_W'(gfe_pkg::POP_MAX - 1)) begin
            item_count_next = item_count_reg + 1'b1;
        end else begin
            item_count_next = item_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg  <= '0;
            best_fit_reg    <= '0;
            best_pos_reg    <= '0;
            best_genes_reg  <= '0;
            worst_fit_reg   <= '0;
            worst_pos_reg   <= '0;
            elite_fit_reg   <= '0;
            elite_chrom_reg <= '0;
        end else if (ctl.upd) begin
            item_count_reg  <= item_count_next;
            best_fit_reg    <= best_fit_next;
            best_pos_reg    <= best_pos_next;
            best_genes_reg  <= best_genes_next;
            worst_fit_reg   <= worst_fit_next;
            worst_pos_reg   <= worst_pos_next;
            elite_fit_reg   <= elite_fit_next;
            elite_chrom_reg <= elite_chrom_next;
        end
    end

    always_comb begin
        result.obj_value       = val;
        result.fitness         = fit_reg;
        result.best_slot       = best_pos_next;
        result.worst_slot      = worst_pos_next;
        result.elite_fitness   = elite_fit_next;
        result.elite_genes     = elite_chrom_next;
        result.generation_done = last;
    end

endmodule

// ===== rtl/gfe_checker.sv =====
module gfe_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [gfe_pkg::CHROM_W-1:0]       s_chromosome,
    input logic                              s_last_item,
    input logic                              s_new_run,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [gfe_pkg::VAL_W-1:0]         m_obj_value,
    input logic [gfe_pkg::FIT_W-1:0]         m_fitness,
    input logic [gfe_pkg::SLOT_W-1:0]        m_best_slot,
    input logic [gfe_pkg::SLOT_W-1:0]        m_worst_slot,
    input logic [gfe_pkg::FIT_W-1:0]         m_elite_fitness,
    input logic [gfe_pkg::CHROM_W-1:0]       m_elite_genes,
    input logic                              m_generation_done
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_obj_value) && $stable(m_fitness)
            && $stable(m_best_slot) && $stable(m_worst_slot) && $stable(m_elite_fitness)
            && $stable(m_elite_genes) && $stable(m_generation_done))
        else $error("result changed while stalled");

    // A waiting input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_chromosome)
            && $stable(s_last_item) && $stable(s_new_run))
        else $error("input item changed while waiting");

    // One item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // A fresh result appears exactly at the sequencer latency after an accept
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 12))
        else $error("result without matching accept");

    // Nothing goes out while the sequencer is still waiting for input
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !m_valid |=> !m_valid)
        else $error("result produced while idle");

endmodule

bind ga_fitness_eval_tracker_unit gfe_checker u_gfe_checker (.*);

// ===== dv/ga_fitness_eval_tracker_unit_tb.sv =====
`timescale 1ns / 100ps

module ga_fitness_eval_tracker_unit_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DIR_ROWS    = 22;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int OVERFLOW_GEN = 560;  // longer than POP_MAX, so the slot index pins
    localparam longint VAL_CAP = (longint'(1) << gfe_pkg::VAL_W) - 1;
    localparam longint FIT_CAP = (longint'(1) << gfe_pkg::FIT_W) - 1;
    localparam logic [gfe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [gfe_pkg::GENE_BITS-1:0] GENE_OPT   = 10'd761;  // x close to 1.0

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [gfe_pkg::CFG_IDX_W-1:0]   addr;
        logic [gfe_pkg::CFG_DATA_W-1:0]  wdata;
        logic [gfe_pkg::CHROM_W-1:0]     chrom;
        logic                            last;
        logic                            new_run;
        logic                            typed;
        logic [gfe_pkg::SLOT_W-1:0]      best;
        logic [gfe_pkg::SLOT_W-1:0]      worst;
        logic                            done;
    } stim_row_t;

    // slot and done values known up front for a directed item
    typedef struct packed {
        logic                       on;
        logic [gfe_pkg::SLOT_W-1:0] best;
        logic [gfe_pkg::SLOT_W-1:0] worst;
        logic                       done;
    } check_hint_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [gfe_pkg::CHROM_W-1:0]    s_chromosome = '0;
    logic                           s_last_item = 1'b0;
    logic                           s_new_run = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [gfe_pkg::VAL_W-1:0]      m_obj_value;
    logic [gfe_pkg::FIT_W-1:0]      m_fitness;
    logic [gfe_pkg::SLOT_W-1:0]     m_best_slot;
    logic [gfe_pkg::SLOT_W-1:0]     m_worst_slot;
    logic [gfe_pkg::FIT_W-1:0]      m_elite_fitness;
    logic [gfe_pkg::CHROM_W-1:0]    m_elite_genes;
    logic                           m_generation_done;
    logic                           cfg_wr_en = 1'b0;
    logic [gfe_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [gfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic                           opt_mode_q = 1'b0;
    logic [gfe_pkg::OFFSET_W-1:0]   offset_q = '0;
    logic [gfe_pkg::CEIL_W-1:0]     ceiling_q = gfe_pkg::CEIL_RESET;

    // predictor copy of the generation and elite state
    logic [gfe_pkg::SLOT_W-1:0]     gen_pos = '0;
    longint                         gen_best_fit = 0;
    logic [gfe_pkg::SLOT_W-1:0]     gen_best_pos = '0;
    logic [gfe_pkg::CHROM_W-1:0]    gen_best_genes = '0;
    longint                         gen_worst_fit = 0;
    logic [gfe_pkg::SLOT_W-1:0]     gen_worst_pos = '0;
    longint                         elite_fit_q = 0;
    logic [gfe_pkg::CHROM_W-1:0]    elite_genes_q = '0;

    gfe_pkg::gfe_result_t pending_results [$];
    check_hint_t typed_hints [$];

    int fail_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 70;

    ga_fitness_eval_tracker_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_chromosome      (s_chromosome),
        .s_last_item       (s_last_item),
        .s_new_run         (s_new_run),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_obj_value       (m_obj_value),
        .m_fitness         (m_fitness),
        .m_best_slot       (m_best_slot),
        .m_worst_slot      (m_worst_slot),
        .m_elite_fitness   (m_elite_fitness),
        .m_elite_genes     (m_elite_genes),
        .m_generation_done (m_generation_done),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Gene to Q16 coordinate, round half away from zero
    function automatic longint gene_coord(input logic [gfe_pkg::GENE_BITS-1:0] g);
        longint m, num, den;
        m = (longint'(1) << gfe_pkg::GENE_BITS) - 1;
        num = 64'sd16777216 * (2 * longint'(g) - m);
        den = 125 * m;
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    // Rosenbrock value in Q16, saturated to the result width
    function automatic longint rosen_value(input logic [gfe_pkg::CHROM_W-1:0] chrom);
        longint x1, x2, ax1, x1sq, d, e, sum, v;
        x1 = gene_coord(chrom[gfe_pkg::GENE_BITS-1:0]);
        x2 = gene_coord(chrom[gfe_pkg::CHROM_W-1:gfe_pkg::GENE_BITS]);
        ax1 = (x1 < 0) ? -x1 : x1;
        x1sq = (ax1 * ax1 + gfe_pkg::HALF_Q16) >> gfe_pkg::FRAC_SHIFT;
        d = (x1sq - x2 < 0) ? x2 - x1sq : x1sq - x2;
        e = (gfe_pkg::ONE_Q16 - x1 < 0) ? x1 - gfe_pkg::ONE_Q16 : gfe_pkg::ONE_Q16 - x1;
        sum = gfe_pkg::ROSEN_K * d * d + e * e;
        v = (sum + gfe_pkg::HALF_Q16) >> gfe_pkg::FRAC_SHIFT;
        return (v > VAL_CAP) ? VAL_CAP : v;
    endfunction

    // Score one individual and advance the best/worst/elite tracking
    function automatic gfe_pkg::gfe_result_t score_item(
            input logic [gfe_pkg::CHROM_W-1:0] chrom,
            input logic last, input logic first_gen);
        gfe_pkg::gfe_result_t r;
        longint val, fit, ceil_q16;
        val = rosen_value(chrom);
        if (opt_mode_q == 1'b0) begin
            fit = val + (longint'(offset_q) << gfe_pkg::FRAC_SHIFT);
        end else begin
            ceil_q16 = longint'(ceiling_q) << gfe_pkg::FRAC_SHIFT;
            fit = (val < ceil_q16) ? ceil_q16 - val : 0;
        end
        if (fit > FIT_CAP)
            fit = FIT_CAP;

        if (gen_pos == '0) begin
            gen_best_fit = fit;
            gen_best_genes = chrom;
            gen_best_pos = '0;
            gen_worst_fit = fit;
            gen_worst_pos = '0;
        end else if (fit > gen_best_fit) begin
            gen_best_fit = fit;
            gen_best_genes = chrom;
            gen_best_pos = gen_pos;
        end else if (fit < gen_worst_fit) begin
            gen_worst_fit = fit;
            gen_worst_pos = gen_pos;
        end

        // elite update closes the generation; count pins at the top slot
        if (last) begin
            if (first_gen || gen_best_fit >= elite_fit_q) begin
                elite_fit_q = gen_best_fit;
                elite_genes_q = gen_best_genes;
            end
            gen_pos = '0;
        end else if (gen_pos < gfe_pkg::POP_MAX - 1) begin
            gen_pos = gen_pos + 1'b1;
        end

        r.obj_value = gfe_pkg::VAL_W'(val);
        r.fitness = gfe_pkg::FIT_W'(fit);
        r.best_slot = gen_best_pos;
        r.worst_slot = gen_worst_pos;
        r.elite_fitness = gfe_pkg::FIT_W'(elite_fit_q);
        r.elite_genes = elite_genes_q;
        r.generation_done = last;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [gfe_pkg::CHROM_W-1:0] random_chrom();
        int pick;
        logic [gfe_pkg::GENE_BITS-1:0] g1, g2;
        pick = $urandom_range(99);
        if (pick < 15) begin
            // around the minimum, so minimize mode sees nonzero fitness
            g1 = gfe_pkg::GENE_BITS'(int'(GENE_OPT) + int'($urandom_range(10)) - 5);
            g2 = gfe_pkg::GENE_BITS'(int'(GENE_OPT) + int'($urandom_range(10)) - 5);
        end else if (pick < 22) begin
            g1 = $urandom_range(1) ? '1 : '0;
            g2 = $urandom_range(1) ? '1 : '0;
        end else begin
            return gfe_pkg::CHROM_W'($urandom_range(0, (1 << gfe_pkg::CHROM_W) - 1));
        end
        return {g2, g1};
    endfunction

    function automatic stim_row_t item_row(input logic [gfe_pkg::CHROM_W-1:0] chrom,
                                           input logic last, input logic new_run);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.chrom = chrom;
        r.last = last;
        r.new_run = new_run;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [gfe_pkg::CHROM_W-1:0] chrom,
                                            input logic last, input logic new_run,
                                            input int best, input int worst,
                                            input logic done);
        stim_row_t r;
        r = item_row(chrom, last, new_run);
        r.typed = 1'b1;
        r.best = gfe_pkg::SLOT_W'(best);
        r.worst = gfe_pkg::SLOT_W'(worst);
        r.done = done;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [gfe_pkg::CFG_IDX_W-1:0] addr,
                                          input logic [gfe_pkg::CFG_DATA_W-1:0] wdata);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.wdata = wdata;
        return r;
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [gfe_pkg::CHROM_W-1:0] chrom, input logic last,
                             input logic first_gen, input check_hint_t hint);
        int gap;
        cfg_wr_en <= 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        typed_hints.push_back(hint);
        s_valid <= 1'b1;
        s_chromosome <= chrom;
        s_last_item <= last;
        s_new_run <= first_gen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_generation(input int size);
        logic last;
        for (int i = 0; i < size; i++) begin
            last = (i == size - 1);
            send_item(random_chrom(), last,
                      last ? ($urandom_range(4) == 0) : 1'($urandom_range(1)), '0);
        end
    endtask

    // Drain: no item offered and every result back
    task automatic settle();
        s_valid <= 1'b0;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gfe_pkg::CFG_IDX_W-1:0] addr,
                             input logic [gfe_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            gfe_pkg::CFG_OPT_MODE:    opt_mode_q = data[0];
            gfe_pkg::CFG_FIT_OFFSET:  offset_q = data[gfe_pkg::OFFSET_W-1:0];
            gfe_pkg::CFG_FIT_CEILING: ceiling_q = data[gfe_pkg::CEIL_W-1:0];
            default: ;
        endcase
    endtask

    // Result sink with random back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Scoreboard: compare results first, then predict newly accepted items
    always @(posedge aclk) begin : scoreboard
        gfe_pkg::gfe_result_t want;
        check_hint_t hint;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got fitness %h",
                             $time, m_fitness);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("obj_value", want.obj_value, m_obj_value);
                    check_field("fitness", want.fitness, m_fitness);
                    check_field("best_slot", want.best_slot, m_best_slot);
                    check_field("worst_slot", want.worst_slot, m_worst_slot);
                    check_field("elite_fitness", want.elite_fitness, m_elite_fitness);
                    check_field("elite_genes", want.elite_genes, m_elite_genes);
                    check_field("generation_done", want.generation_done,
                                m_generation_done);
                end
            end
            if (s_valid && s_ready) begin
                hint = typed_hints.pop_front();
                want = score_item(s_chromosome, s_last_item, s_new_run);
                if (hint.on) begin
                    want.best_slot = hint.best;
                    want.worst_slot = hint.worst;
                    want.generation_done = hint.done;
                end
                pending_results.push_back(want);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t rows [DIR_ROWS];
        check_hint_t hint;
        logic prev_item;
        logic [gfe_pkg::CFG_DATA_W-1:0] mode_d, off_d, ceil_d;
        int phase_start;

        rows = '{
            // reset config: maximize, no offset; new_run ignored off the last item
            typed_row('0, 1'b0, 1'b1, 0, 0, 1'b0),
            item_row('1, 1'b0, 1'b0),
            item_row({10'd0, 10'h3FF}, 1'b0, 1'b0),
            item_row({10'h3FF, 10'd0}, 1'b0, 1'b0),
            item_row({GENE_OPT, GENE_OPT}, 1'b0, 1'b0),
            item_row({10'd511, 10'd512}, 1'b0, 1'b0),
            item_row({10'h2AA, 10'h155}, 1'b1, 1'b1),
            // one-item generation
            typed_row({GENE_OPT, GENE_OPT}, 1'b1, 1'b0, 0, 0, 1'b1),
            // minimize with zero ceiling: every fitness floors at zero
            cfg_row(gfe_pkg::CFG_OPT_MODE, 12'hFFF),
            cfg_row(gfe_pkg::CFG_FIT_CEILING, 12'h000),
            typed_row({10'h155, 10'h2AA}, 1'b0, 1'b0, 0, 0, 1'b0),
            typed_row('1, 1'b0, 1'b0, 0, 0, 1'b0),
            typed_row('0, 1'b1, 1'b1, 0, 0, 1'b1),
            // tie with a zero elite still replaces it
            typed_row('1, 1'b1, 1'b0, 0, 0, 1'b1),
            // full-scale ceiling; offset ignored in this mode
            cfg_row(gfe_pkg::CFG_FIT_CEILING, 12'hFFF),
            cfg_row(gfe_pkg::CFG_FIT_OFFSET, 12'hFFF),
            typed_row({GENE_OPT, GENE_OPT}, 1'b0, 1'b0, 0, 0, 1'b0),
            typed_row('0, 1'b0, 1'b0, 0, 1, 1'b0),
            typed_row('1, 1'b1, 1'b0, 0, 1, 1'b1),
            // unmapped index must not disturb anything
            cfg_row(CFG_UNUSED, 12'hFFF),
            cfg_row(gfe_pkg::CFG_OPT_MODE, 12'h000),
            typed_row('0, 1'b1, 1'b1, 0, 0, 1'b1)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        prev_item = 1'b1;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                if (prev_item)
                    settle();
                write_reg(rows[i].addr, rows[i].wdata);
            end else begin
                hint.on = rows[i].typed;
                hint.best = rows[i].best;
                hint.worst = rows[i].worst;
                hint.done = rows[i].done;
                send_item(rows[i].chrom, rows[i].last, rows[i].new_run, hint);
            end
            prev_item = (rows[i].kind == ROW_ITEM);
        end

        // random phases, one register setting each
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct = 10;
                recv_idle_pct = 70;
            end else if (p < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            mode_d = gfe_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            off_d = gfe_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            ceil_d = gfe_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            case (p)
                0: begin mode_d = 12'h000; off_d = 12'h000; ceil_d = 12'd100; end
                1: begin mode_d = 12'h000; off_d = 12'hBFF; ceil_d = 12'h000; end
                2: mode_d = 12'h001;
                3: begin mode_d = 12'h001; off_d = 12'h000; ceil_d = 12'hFFF; end
                4: begin mode_d = 12'hFFF; ceil_d = 12'd100; end
                default: ;
            endcase
            write_reg(gfe_pkg::CFG_OPT_MODE, mode_d);
            write_reg(gfe_pkg::CFG_FIT_OFFSET, off_d);
            write_reg(gfe_pkg::CFG_FIT_CEILING, ceil_d);
            if (p == RAND_PHASES - 1)
                write_reg(CFG_UNUSED, gfe_pkg::CFG_DATA_W'($urandom_range(0, 4095)));

            phase_start = items_sent;
            if (p == 3)
                send_generation(OVERFLOW_GEN);
            while (items_sent - phase_start < PHASE_ITEMS)
                send_generation(($urandom_range(9) == 0) ? $urandom_range(13, 60)
                                                         : $urandom_range(1, 12));
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
